// ----- design/ccmd5_pkg.sv -----
// Package with the constants and tables of the modified-MD5 container checksum.
package ccmd5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] HEADER_SKIP = 32'd20;
  localparam logic [31:0] MIN_CONTAINER = 32'd32;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] SPLIT_REM = 6'd56;

  // Per-step additive constants.
  function automatic logic [31:0] add_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Message word chosen at each step.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] w;
    j = i[3:0];
    unique case (i[5:4])
      2'd0: w = j;
      2'd1: w = 4'(5 * j + 1);
      2'd2: w = 4'(3 * j + 5);
      default: w = 4'(7 * j);
    endcase
    return w;
  endfunction

  // Left-rotate amount of each step.
  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ----- design/container_checksum_md5_variant_top.sv -----
// Top level of the modified-MD5 container checksum with its step sequencer.
//
// Usage: the container is sent one byte per beat on the in_ channel, tdata
// carrying the byte and tlast marking its final byte. The first 20 bytes are
// skipped; later bytes fill a 64-byte block buffer. One result beat follows
// each tlast beat on the out_ channel with the four chaining words; a
// container under 32 bytes gives an all-zero digest.
// Flow: a byte that does not complete a block leaves in_tready high for the
// next byte. A byte completing a block runs the compression: one MD5 step per
// cycle through a single shared step unit, the 64 steps and then a fold of the
// result, and in_tready stays low until the fold is done. On tlast, the tail
// blocks take one or two compressions before out_tvalid rises; a short
// container goes straight to the output register.
// The result sits in an output register; in_tready stays low until it has
// been taken, so a stalled receiver stalls the input.
// Reset (rst_n low, synchronous) loads the MD5 initial values, clears the
// count and drops out_tvalid. After each result the state returns to that
// reset state for the next container.
module container_checksum_md5_variant_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] digest_words_first, [127:64] digest_words_second
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_FOLD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BK_DATA, BK_PADONLY, BK_LENONLY, BK_COMBINED
  } blk_kind_t;

  state_t      state_r;
  blk_kind_t   kind_r;
  // Block buffer held as 16 little-endian words.
  logic [31:0] buf_r [16];
  logic [31:0] count_r;
  logic        wrapped_r;
  logic        final_r;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  step_r;
  logic [31:0] nbits_r;
  logic [5:0]  rem_r;
  logic [127:0] out_r;

  logic        accept;
  logic        hashed;
  logic [31:0] pos32;
  logic [5:0]  pos;
  logic [31:0] count_inc;
  logic        wrap_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_r;
  assign accept     = in_tvalid && in_tready;
  assign hashed     = wrapped_r || (count_r >= ccmd5_pkg::HEADER_SKIP);
  assign pos32      = count_r - ccmd5_pkg::HEADER_SKIP;
  assign pos        = pos32[5:0];
  assign count_inc  = count_r + 32'd1;
  assign wrap_inc   = wrapped_r || (count_inc == 32'd0);

  // Message word for the current step, built from the block kind. The
  // combined block shifts the buffer by one word, so its bytes come from
  // the previous buffer word.
  logic [3:0]  widx;
  logic [31:0] mword;
  logic [31:0] cur_w, prv_w;
  logic [7:0]  mb [4];
  always_comb begin
    widx  = ccmd5_pkg::word_sel(step_r);
    cur_w = buf_r[widx];
    prv_w = buf_r[widx - 4'd1];
    for (int k = 0; k < 4; k++) begin
      logic [5:0] bi;
      logic [5:0] src;
      bi  = {widx, 2'(k)};
      src = bi - 6'd4;
      unique case (kind_r)
        BK_DATA: mb[k] = cur_w[8*k +: 8];
        BK_PADONLY: begin
          if (bi < rem_r) mb[k] = cur_w[8*k +: 8];
          else if (bi == rem_r) mb[k] = ccmd5_pkg::PAD_BYTE;
          else mb[k] = 8'h00;
        end
        default: begin
          mb[k] = 8'h00;
          if (bi < 6'd4) mb[k] = nbits_r[8*k +: 8];
          else if (kind_r == BK_COMBINED && bi < 6'd60 && src < rem_r) mb[k] = prv_w[8*k +: 8];
          else if (kind_r == BK_COMBINED && bi < 6'd60 && src == rem_r)
            mb[k] = ccmd5_pkg::PAD_BYTE;
          else if (bi >= 6'd60) mb[k] = 8'(((nbits_r >> 2) | 32'd1) >> (8*k));
        end
      endcase
    end
    mword = {mb[3], mb[2], mb[1], mb[0]};
  end

  // Shared MD5 step unit.
  logic [31:0] f, t, rot;
  logic [4:0]  s;
  always_comb begin
    unique case (step_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s   = ccmd5_pkg::rot_amt(step_r);
    t   = a_r + f + mword + ccmd5_pkg::add_const(step_r);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  // Byte buffer write into its lane of the addressed word.
  always_ff @(posedge clk) begin
    if (accept && hashed) buf_r[pos[5:2]][8*pos[1:0] +: 8] <= in_tdata;
  end

  // Sequencer, chaining words and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      wrapped_r <= 1'b0;
      final_r   <= 1'b0;
      h_r[0] <= ccmd5_pkg::IV_A; h_r[1] <= ccmd5_pkg::IV_B;
      h_r[2] <= ccmd5_pkg::IV_C; h_r[3] <= ccmd5_pkg::IV_D;
      step_r    <= '0;
      kind_r    <= BK_DATA;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            logic [31:0] len;
            count_r   <= count_inc;
            wrapped_r <= wrap_inc;
            len       = count_inc - ccmd5_pkg::HEADER_SKIP;
            nbits_r   <= len << 3;
            rem_r     <= len[5:0];
            step_r    <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
            final_r   <= in_tlast;
            if (hashed && pos == 6'd63) begin
              kind_r  <= BK_DATA;
              state_r <= ST_STEP;
            end else if (in_tlast) begin
              if (wrap_inc || count_inc >= ccmd5_pkg::MIN_CONTAINER) begin
                kind_r  <= (len[5:0] >= ccmd5_pkg::SPLIT_REM) ? BK_PADONLY : BK_COMBINED;
                state_r <= ST_STEP;
              end else begin
                out_r   <= '0;
                state_r <= ST_OUT;
              end
            end
          end
        end
        ST_STEP: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          logic [31:0] n0, n1, n2, n3;
          n0 = h_r[0] + a_r; n1 = h_r[1] + b_r; n2 = h_r[2] + c_r; n3 = h_r[3] + d_r;
          h_r[0] <= n0; h_r[1] <= n1; h_r[2] <= n2; h_r[3] <= n3;
          a_r <= n0; b_r <= n1; c_r <= n2; d_r <= n3;
          step_r <= '0;
          priority if (!final_r) begin
            state_r <= ST_IDLE;
          end else if (kind_r == BK_DATA) begin
            if (wrapped_r || count_r >= ccmd5_pkg::MIN_CONTAINER) begin
              kind_r  <= (rem_r >= ccmd5_pkg::SPLIT_REM) ? BK_PADONLY : BK_COMBINED;
              state_r <= ST_STEP;
            end else begin
              out_r   <= '0;
              state_r <= ST_OUT;
            end
          end else if (kind_r == BK_PADONLY) begin
            kind_r  <= BK_LENONLY;
            state_r <= ST_STEP;
          end else begin
            out_r   <= {n3, n2, n1, n0};
            state_r <= ST_OUT;
          end
        end
        default: begin
          if (out_tready) begin
            state_r   <= ST_IDLE;
            count_r   <= '0;
            wrapped_r <= 1'b0;
            final_r   <= 1'b0;
            kind_r    <= BK_DATA;
            h_r[0] <= ccmd5_pkg::IV_A; h_r[1] <= ccmd5_pkg::IV_B;
            h_r[2] <= ccmd5_pkg::IV_C; h_r[3] <= ccmd5_pkg::IV_D;
          end
        end
      endcase
    end
  end

endmodule
